### hw/rtl/alu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_pkg
// Shared types and command codes for the 64-bit ALU with HI/LO registers.
// ----------------------------------------------------------------------------
package alu_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned CntW  = 7;

    typedef enum logic [4:0] {
        CMD_AND   = 5'd0,
        CMD_ADD   = 5'd1,
        CMD_DADD  = 5'd2,
        CMD_SUB   = 5'd3,
        CMD_DSUB  = 5'd4,
        CMD_DIV   = 5'd5,
        CMD_DDIV  = 5'd6,
        CMD_MULT  = 5'd7,
        CMD_DMULT = 5'd8,
        CMD_OR    = 5'd9,
        CMD_XOR   = 5'd10,
        CMD_NOT   = 5'd11,
        CMD_SLL   = 5'd12,
        CMD_DSLL  = 5'd13,
        CMD_SRL   = 5'd14,
        CMD_DSRL  = 5'd15,
        CMD_MFLO  = 5'd16,
        CMD_MFHI  = 5'd17,
        CMD_MOVN  = 5'd18,
        CMD_MOVZ  = 5'd19
    } t_cmd;

    typedef struct packed {
        logic [4:0]       cmd;
        logic [63:0]      operand_a;
        logic [63:0]      operand_b;
    } t_in;

    typedef struct packed {
        logic [63:0] result_value;
        logic        write_dest;
        logic        divide_by_zero;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic simple;    // finish a simple op into output register
        logic mul_start; // start multiply
        logic div_start; // start divide
        logic step_mul;  // one partial product
        logic step_div;  // one quotient bit
        logic mul_done;  // write LO from product
        logic div_done;  // write HI/LO from quotient and remainder
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic last;
    } t_stat;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/alu64_with_hi_lo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu64_with_hi_lo
// 64-bit integer ALU with HI/LO registers, multi-cycle multiply and divide.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      i_in_valid/o_in_ready   t_in  (cmd, operand_a, operand_b)
// out      output     o_out_valid/i_out_ready t_out (result_value, write_dest,
//                                                    divide_by_zero)
//
// Simple ops: decoded and computed into the output register, held until taken.
// Multiply: 4 steps of a 64x16 partial product.
// Divide: 64 steps of a radix-2 restoring divider.
// One item at a time; a new item is taken once the result has transferred.
// Reset returns the controller to idle and clears HI/LO to zero.
// ----------------------------------------------------------------------------
module alu64_with_hi_lo
    import alu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    t_ctrl ctrl_raw, ctrl;
    t_stat stat;

    alu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl_raw)
    );

    alu_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl_raw),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    alu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

### hw/rtl/alu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_dp
// Datapath: operand registers, simple-op logic, radix-2 divider, 16-bit
// by 64-bit multiply steps, HI/LO registers and output register.
// ----------------------------------------------------------------------------
module alu_dp
    import alu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_in,
    input  wire t_ctrl i_ctrl,
    output t_stat      o_stat,
    output t_out       o_out
);

    logic [4:0]  r_cmd;
    logic [63:0] r_a, r_b;
    logic [63:0] r_hi, r_lo;
    logic [63:0] r_acc, n_acc;    // product or remainder
    logic [63:0] r_q, n_q;        // dividend shifter / quotient
    logic [63:0] r_d;             // divisor magnitude
    logic        r_qneg, r_rneg, r_word;
    logic [CntW-1:0] r_cnt;
    t_out        r_out, n_out;

    logic [63:0] dv_a, dv_b, mag_a, mag_b, trial_sh;
    logic [64:0] trial;
    logic [79:0] pp;
    logic [63:0] q_fin, r_fin;
    t_cmd        cmd_e;

    assign cmd_e = t_cmd'(r_cmd);

    // divider operand selection
    always_comb begin
        dv_a  = (cmd_e == CMD_DIV) ? sext32(r_a) : r_a;
        dv_b  = (cmd_e == CMD_DIV) ? sext32(r_b) : r_b;
        mag_a = dv_a[63] ? (64'd0 - dv_a) : dv_a;
        mag_b = dv_b[63] ? (64'd0 - dv_b) : dv_b;
    end

    assign o_stat.is_mul   = (cmd_e == CMD_MULT) || (cmd_e == CMD_DMULT);
    assign o_stat.is_div   = (cmd_e == CMD_DIV) || (cmd_e == CMD_DDIV);
    assign o_stat.div_zero = (dv_b == 64'd0);
    assign o_stat.last     = (r_cnt == '0);

    // one restoring divide step and one multiply partial product
    assign trial_sh = {r_acc[62:0], r_q[63]};
    assign trial    = {r_acc, r_q[63]} - {1'b0, r_d};
    assign pp       = r_a * r_b[15:0];

    always_comb begin
        q_fin = r_qneg ? (64'd0 - r_q) : r_q;
        r_fin = r_rneg ? (64'd0 - r_acc) : r_acc;
        if (r_word) begin
            q_fin = sext32(q_fin);
            r_fin = sext32(r_fin);
        end
    end

    // simple-op results
    always_comb begin
        n_out = '0;
        n_out.write_dest = 1'b1;
        case (r_cmd)
            CMD_AND:  n_out.result_value = r_a & r_b;
            CMD_ADD:  n_out.result_value = sext32(r_a + r_b);
            CMD_DADD: n_out.result_value = r_a + r_b;
            CMD_SUB:  n_out.result_value = sext32(r_a - r_b);
            CMD_DSUB: n_out.result_value = r_a - r_b;
            CMD_OR:   n_out.result_value = r_a | r_b;
            CMD_XOR:  n_out.result_value = r_a ^ r_b;
            CMD_NOT:  n_out.result_value = ~r_a;
            CMD_SLL:  n_out.result_value = sext32({32'd0, r_a[31:0] << r_b[4:0]});
            CMD_DSLL: n_out.result_value = r_a << r_b[5:0];
            CMD_SRL:  n_out.result_value = sext32({32'd0, r_a[31:0] >> r_b[4:0]});
            CMD_DSRL: n_out.result_value = r_a >> r_b[5:0];
            CMD_MFLO: n_out.result_value = r_lo;
            CMD_MFHI: n_out.result_value = r_hi;
            CMD_MOVN: begin
                if (r_b != 64'd0) n_out.result_value = r_a;
                else n_out.write_dest = 1'b0;
            end
            CMD_MOVZ: begin
                if (r_b == 64'd0) n_out.result_value = r_a;
                else n_out.write_dest = 1'b0;
            end
            default: begin
                n_out.write_dest     = 1'b0;
                n_out.divide_by_zero = o_stat.is_div && o_stat.div_zero;
            end
        endcase
    end

    // next accumulator and shifter; the lowest 16-bit slice comes first
    always_comb begin
        n_acc = r_acc;
        n_q   = r_q;
        if (i_ctrl.step_div) begin
            if (!trial[64]) begin
                n_acc = trial[63:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_acc = trial_sh;
                n_q   = {r_q[62:0], 1'b0};
            end
        end else if (i_ctrl.step_mul) begin
            n_acc = r_acc + (pp[63:0] << {~r_cnt[1:0], 4'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        // capture operands
        if (i_ctrl.load) begin
            r_cmd <= i_in.cmd;
            r_a   <= i_in.operand_a;
            r_b   <= i_in.operand_b;
        end
        // start and advance multi-cycle ops
        if (i_ctrl.mul_start) begin
            r_acc <= '0;
            r_cnt <= CntW'(3);
        end else if (i_ctrl.div_start) begin
            r_acc  <= '0;
            r_q    <= mag_a;
            r_d    <= mag_b;
            r_qneg <= dv_a[63] ^ dv_b[63];
            r_rneg <= dv_a[63];
            r_word <= (cmd_e == CMD_DIV);
            r_cnt  <= CntW'(63);
        end else if (i_ctrl.step_mul) begin
            r_acc <= n_acc;
            r_b   <= r_b >> 16;
            r_cnt <= r_cnt - CntW'(1);
        end else if (i_ctrl.step_div) begin
            r_acc <= n_acc;
            r_q   <= n_q;
            r_cnt <= r_cnt - CntW'(1);
        end
        // finish into output register
        if (i_ctrl.simple || i_ctrl.mul_done || i_ctrl.div_done) begin
            r_out <= i_ctrl.simple ? n_out : '0;
        end
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_ctrl.mul_done) begin
            r_lo <= (cmd_e == CMD_MULT) ? sext32(r_acc) : r_acc;
        end else if (i_ctrl.div_done) begin
            r_lo <= q_fin;
            r_hi <= r_fin;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

### hw/rtl/alu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_ctrl
// Controller: accepts an item, runs the multiply or divide sequence, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module alu_ctrl
    import alu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.load = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.is_mul) begin
                    o_ctrl.mul_start = 1'b1;
                    n_state = S_MUL;
                end else if (i_stat.is_div && !i_stat.div_zero) begin
                    o_ctrl.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_ctrl.simple = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                o_ctrl.step_mul = 1'b1;
                if (i_stat.last) n_state = S_FIN;
                o_ctrl.mul_done = 1'b0;
            end
            S_DIV: begin
                o_ctrl.step_div = 1'b1;
                if (i_stat.last) n_state = S_FIN;
            end
            // write-back cycle: HI/LO and the output register update here
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/alu_fin.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_fin
// Finish sequencer: raises the write-back strobe for multiply and divide
// in the cycle after their last step.
// ----------------------------------------------------------------------------
module alu_fin
    import alu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctrl i_ctrl,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    logic r_mul_fin, r_div_fin;

    // flag the step that ends the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_fin <= 1'b0;
            r_div_fin <= 1'b0;
        end else begin
            r_mul_fin <= i_ctrl.step_mul && i_stat.last;
            r_div_fin <= i_ctrl.step_div && i_stat.last;
        end
    end

    always_comb begin
        o_ctrl          = i_ctrl;
        o_ctrl.mul_done = r_mul_fin;
        o_ctrl.div_done = r_div_fin;
    end

endmodule
`default_nettype wire

### hw/rtl/alu_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu_chk
// Port checker for the ALU, bound to the top level.
// ----------------------------------------------------------------------------
module alu_chk
    import alu_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire t_in  i_in,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out
);

    // never ready for input while a result is held
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result held");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // no result in the cycle right after a transfer in
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid) else $error("early result");

    // divide by zero flag never comes with a write
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.divide_by_zero |-> !o_out.write_dest)
        else $error("write with divide by zero");

endmodule

bind alu64_with_hi_lo alu_chk u_chk (.*);
`default_nettype wire
